FILE: rtl/iks_pkg.sv
`timescale 1ns / 1ps
// Package for the identifier and keyword token scanner.
// Holds the request and result types, token codes, character constants
// and the C keyword table. No dependencies.
package iks_pkg;

  localparam int unsigned KeywordMaxLenDef = 8;
  localparam int unsigned NameLenMaxDef    = 255;
  localparam int unsigned KwCount          = 32;
  localparam int unsigned KwIdxW           = 5;
  localparam int unsigned KwTextMax        = 8;
  localparam int unsigned QueueDepth       = 2;
  localparam logic [7:0]  NameLenShowMax   = 8'd255;

  localparam logic [2:0] KindKeyword = 3'd0;
  localparam logic [2:0] KindIdent   = 3'd1;
  localparam logic [2:0] KindAssign  = 3'd2;
  localparam logic [2:0] KindOper    = 3'd3;
  localparam logic [2:0] KindEnd     = 3'd4;

  localparam logic [7:0] ChPlus   = "+";
  localparam logic [7:0] ChMinus  = "-";
  localparam logic [7:0] ChStar   = "*";
  localparam logic [7:0] ChSlash  = "/";
  localparam logic [7:0] ChPct    = "%";
  localparam logic [7:0] ChEq     = "=";
  localparam logic [7:0] ChUscore = "_";
  localparam logic [7:0] ChLowerA = "a";
  localparam logic [7:0] ChLowerZ = "z";
  localparam logic [7:0] ChUpperA = "A";
  localparam logic [7:0] ChUpperZ = "Z";
  localparam logic [7:0] ChZero   = "0";
  localparam logic [7:0] ChNine   = "9";

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [4:0] keyword_index;
    logic [7:0] name_length;
    logic [7:0] token_char;
    logic       name_truncated;
    logic       last;
  } out_item_t;

  // one request from the front to the back: optional name token, then a single token
  typedef struct packed {
    logic              has_name;
    logic              name_is_kw;
    logic [KwIdxW-1:0] kw_idx;
    logic [7:0]        name_len;
    logic              name_trunc;
    logic [2:0]        single_kind;
    logic [7:0]        single_char;
  } iks_cmd_t;

  // keyword text, right aligned: the last character sits in bits [7:0]
  function automatic logic [8*KwTextMax-1:0] kw_text(input int unsigned i);
    logic [8*KwTextMax-1:0] t;
    case (i)
      0:  t = "int";
      1:  t = "auto";
      2:  t = "break";
      3:  t = "case";
      4:  t = "char";
      5:  t = "const";
      6:  t = "continue";
      7:  t = "default";
      8:  t = "do";
      9:  t = "double";
      10: t = "else";
      11: t = "enum";
      12: t = "extern";
      13: t = "float";
      14: t = "for";
      15: t = "goto";
      16: t = "if";
      17: t = "long";
      18: t = "register";
      19: t = "return";
      20: t = "short";
      21: t = "signed";
      22: t = "sizeof";
      23: t = "static";
      24: t = "struct";
      25: t = "switch";
      26: t = "typedef";
      27: t = "union";
      28: t = "unsigned";
      29: t = "void";
      30: t = "volatile";
      31: t = "while";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic int unsigned kw_len(input int unsigned i);
    int unsigned n;
    case (i)
      8, 16:                                  n = 2;
      0, 14:                                  n = 3;
      1, 3, 4, 10, 11, 15, 17, 29:            n = 4;
      2, 5, 13, 20, 27, 31:                   n = 5;
      9, 12, 19, 21, 22, 23, 24, 25:          n = 6;
      7, 26:                                  n = 7;
      6, 18, 28, 30:                          n = 8;
      default:                                n = 0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/iks_front.sv
`timescale 1ns / 1ps
// Front end: takes characters, tracks the current name and matches keywords.
// Emits one request per item that ends a name or gives a token. Uses iks_pkg.
module iks_front #(
  parameter int unsigned KeywordMaxLen = iks_pkg::KeywordMaxLenDef,
  parameter int unsigned NameLenMax    = iks_pkg::NameLenMaxDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  iks_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  output iks_pkg::iks_cmd_t cmd_o
);
  import iks_pkg::*;

  localparam int unsigned CntW = $clog2(NameLenMax + 1);

  logic            in_name_q, in_name_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      prefix_q [KeywordMaxLen];

  logic [7:0] ch;
  logic       is_end, is_alpha, is_digit, name_ch, name_start;
  logic [KwCount-1:0] kw_hit;
  logic [KwIdxW-1:0]  kw_idx;
  logic [7:0]         len_show;

  assign ch         = in_item_i.ch;
  assign is_end     = in_item_i.is_end;
  assign is_alpha   = ((ch >= ChLowerA) && (ch <= ChLowerZ)) ||
                      ((ch >= ChUpperA) && (ch <= ChUpperZ)) || (ch == ChUscore);
  assign is_digit   = (ch >= ChZero) && (ch <= ChNine);
  assign name_ch    = !is_end && (is_alpha || is_digit);
  assign name_start = !is_end && is_alpha;

  // keyword compare against the stored prefix
  for (genvar i = 0; i < KwCount; i++) begin : g_kw
    localparam logic [8*KwTextMax-1:0] Txt = kw_text(i);
    localparam int unsigned            Len = kw_len(i);
    logic [KwTextMax-1:0] eq;
    for (genvar j = 0; j < KwTextMax; j++) begin : g_ch
      if (j < Len) begin : g_cmp
        assign eq[j] = (prefix_q[j] == Txt[8*(Len-1-j) +: 8]);
      end else begin : g_pad
        assign eq[j] = 1'b1;
      end
    end
    assign kw_hit[i] = !ovf_q && (count_q == CntW'(Len)) && (&eq);
  end

  always_comb begin
    kw_idx = '0;
    for (int i = KwCount - 1; i >= 0; i--) begin
      if (kw_hit[i]) begin
        kw_idx = KwIdxW'(i);
      end
    end
  end

  assign len_show = (count_q > CntW'(NameLenShowMax)) ? NameLenShowMax : 8'(count_q);

  always_comb begin
    in_name_d   = in_name_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    cmd_valid_o = 1'b0;

    cmd_o.has_name    = in_name_q;
    cmd_o.name_is_kw  = |kw_hit;
    cmd_o.kw_idx      = kw_idx;
    cmd_o.name_len    = len_show;
    cmd_o.name_trunc  = ovf_q;
    cmd_o.single_kind = KindEnd;
    cmd_o.single_char = '0;
    if (!is_end && ch == ChEq) begin
      cmd_o.single_kind = KindAssign;
      cmd_o.single_char = ch;
    end else if (!is_end && (ch == ChPlus || ch == ChMinus || ch == ChStar ||
                             ch == ChSlash || ch == ChPct)) begin
      cmd_o.single_kind = KindOper;
      cmd_o.single_char = ch;
    end

    if (accept_i) begin
      if (in_name_q) begin
        if (name_ch) begin
          if (count_q < CntW'(NameLenMax)) begin
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          in_name_d   = 1'b0;
          cmd_valid_o = 1'b1;
        end
      end else if (name_start) begin
        in_name_d = 1'b1;
        count_d   = CntW'(1);
        ovf_d     = 1'b0;
      end else begin
        cmd_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_name_q <= 1'b0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
    end else begin
      in_name_q <= in_name_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
    end
  end

  // prefix store, no reset: only entries of the current name are read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (!in_name_q && name_start) begin
        prefix_q[0] <= ch;
      end else if (in_name_q && name_ch) begin
        for (int k = 0; k < KeywordMaxLen; k++) begin
          if (count_q == CntW'(k)) begin
            prefix_q[k] <= ch;
          end
        end
      end
    end
  end

endmodule

FILE: rtl/iks_queue.sv
`timescale 1ns / 1ps
// Short request queue between front and back end.
// Depth from iks_pkg::QueueDepth; carries iks_cmd_t.
module iks_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  iks_pkg::iks_cmd_t wdata_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              nonempty_o,
  output iks_pkg::iks_cmd_t rdata_o
);
  import iks_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  iks_cmd_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign nonempty_o = (cnt_q != '0);
  assign rdata_o    = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_i) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_i) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/iks_back.sv
`timescale 1ns / 1ps
// Back end: expands each request into one or two results and holds the
// oldest result in an output register. Uses iks_pkg.
module iks_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_nonempty_i,
  input  iks_pkg::iks_cmd_t  cmd_i,
  output logic               cmd_rd_o,
  output logic               empty,
  input  logic               pop,
  output iks_pkg::out_item_t out_item_o
);
  import iks_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      phase_q, phase_d;
  out_item_t out_q, out_d;
  logic      load, name_step;

  assign load      = cmd_nonempty_i && (!out_valid_q || pop);
  assign name_step = cmd_i.has_name && !phase_q;
  assign cmd_rd_o  = load && !name_step;

  always_comb begin
    out_valid_d = out_valid_q;
    phase_d     = phase_q;
    out_d       = out_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (name_step) begin
        phase_d              = 1'b1;
        out_d.token_kind     = cmd_i.name_is_kw ? KindKeyword : KindIdent;
        out_d.keyword_index  = cmd_i.name_is_kw ? cmd_i.kw_idx : '0;
        out_d.name_length    = cmd_i.name_len;
        out_d.token_char     = '0;
        out_d.name_truncated = cmd_i.name_trunc;
        out_d.last           = 1'b0;
      end else begin
        phase_d              = 1'b0;
        out_d.token_kind     = cmd_i.single_kind;
        out_d.keyword_index  = '0;
        out_d.name_length    = '0;
        out_d.token_char     = cmd_i.single_char;
        out_d.name_truncated = 1'b0;
        out_d.last           = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

endmodule

FILE: rtl/identifier_keyword_token_scanner_core.sv
`timescale 1ns / 1ps
// Identifier and keyword token scanner, top level.
// Input queue side: in_item_i (one character or an end mark) is taken on a
// clock edge with push high and full low. Output queue side: the oldest token
// sits on out_item_o while empty is low and leaves on an edge with pop high.
// The front end tracks names and matches the 32 C keywords from the stored
// prefix; a two-entry request queue decouples it from the back end, which
// writes tokens into an output register.
// An accepted item's request passes through the queue, then its first token is
// loaded into the output register; the second token of a name end follows it.
// Throughput: one item per cycle while full is low. An item that ends a name gives
// two tokens, which the back end loads one after the other; if the very next item
// also gives a token, the queue fills and full is high for one cycle.
// A stalled receiver holds the output register; the queue then fills and full
// stops further input. Nothing is lost or repeated.
// Reset clears name state, queue and output valid; no clearing pass is needed.
// Uses iks_pkg, iks_front, iks_queue, iks_back.
module identifier_keyword_token_scanner_core #(
  parameter int unsigned KeywordMaxLen = iks_pkg::KeywordMaxLenDef,
  parameter int unsigned NameLenMax    = iks_pkg::NameLenMaxDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  iks_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output iks_pkg::out_item_t out_item_o
);
  import iks_pkg::*;

  logic     accept, cmd_valid, q_full, q_nonempty, q_rd;
  iks_cmd_t cmd_wr, cmd_rd;

  assign full   = q_full;
  assign accept = push && !q_full;

  iks_front #(
    .KeywordMaxLen(KeywordMaxLen),
    .NameLenMax   (NameLenMax)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd_wr)
  );

  iks_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_valid),
    .wdata_i   (cmd_wr),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .nonempty_o(q_nonempty),
    .rdata_o   (cmd_rd)
  );

  iks_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_nonempty_i(q_nonempty),
    .cmd_i         (cmd_rd),
    .cmd_rd_o      (q_rd),
    .empty         (empty),
    .pop           (pop),
    .out_item_o    (out_item_o)
  );

endmodule
